### design/ahq_pkg.sv
package ahq_pkg;

    localparam int SAMPLE_COUNT = 8;

    localparam int SAMPLE_W  = 10;
    localparam int SUM_W     = 16;
    localparam int CNT_W     = $clog2(SAMPLE_COUNT + 1);
    localparam int NBIN_W    = 7;
    localparam int BIN_W     = 6;
    localparam int MARGIN_W  = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 10'd1023;
    localparam logic [NBIN_W-1:0]   MAX_BINS   = 7'd64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN     = 2'd1;

    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] average;
        logic [NBIN_W-1:0]   item_count;
        logic [MARGIN_W-1:0] margin;
    } calc_req_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [BIN_W-1:0]    bin_index;
        logic                bin_changed;
    } result_t;

endpackage

### design/ahq_calc.sv
module ahq_calc (
    input  logic              clk,
    input  logic              rst_n,
    input  ahq_pkg::calc_req_t req,
    input  logic              ack,
    output logic              busy,
    output logic              done,
    output ahq_pkg::result_t  result
);
    import ahq_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_A  = 3'd1;
    localparam logic [2:0] ST_DIV_A  = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_DIV_S  = 3'd4;
    localparam logic [2:0] ST_MUL_C  = 3'd5;
    localparam logic [2:0] ST_CHECK  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    localparam logic [3:0] DIV_LAST   = 4'(SUM_W - 1);
    localparam logic [3:0] MUL_A_LAST = 4'(NBIN_W - 1);
    localparam logic [3:0] MUL_C_LAST = 4'(BIN_W - 1);

    // control
    logic [2:0]          state_reg, state_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [BIN_W-1:0]    cur_reg, cur_next;
    logic                bvalid_reg, bvalid_next;

    // datapath
    logic [NBIN_W-1:0]   n_reg, n_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic [MARGIN_W-1:0] margin_reg, margin_next;
    logic [SUM_W-1:0]    mcand_reg, mcand_next;
    logic [NBIN_W-1:0]   mplr_reg, mplr_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [SUM_W-1:0]    dvd_reg, dvd_next;
    logic [SAMPLE_W-1:0] rem_reg, rem_next;
    logic [SAMPLE_W-1:0] dvsr_reg, dvsr_next;
    logic [SAMPLE_W-1:0] step_reg, step_next;
    logic [BIN_W-1:0]    idx_reg, idx_next;
    logic [BIN_W-1:0]    res_bin_reg, res_bin_next;
    logic                changed_reg, changed_next;

    logic [SAMPLE_W:0]   trial;
    logic                fits;
    logic [SAMPLE_W-1:0] rem_step;
    logic [SUM_W-1:0]    dvd_step;
    logic [SUM_W-1:0]    mul_sum;
    logic [NBIN_W-1:0]   n_clamp;
    logic [BIN_W-1:0]    idx_calc;
    logic [SAMPLE_W-2:0] half_step;
    logic [SUM_W:0]      center;
    logic [SUM_W:0]      avg_wide;
    logic [SUM_W:0]      avg_dist;
    logic [MARGIN_W:0]   limit;
    logic                far;

    // one restoring division step per cycle
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[SUM_W-1]};
        fits     = (trial >= {1'b0, dvsr_reg});
        rem_step = fits ? SAMPLE_W'(trial - {1'b0, dvsr_reg}) : trial[SAMPLE_W-1:0];
        dvd_step = {dvd_reg[SUM_W-2:0], fits};
    end

    // one shift-add multiply step per cycle
    assign mul_sum = acc_reg + (mplr_reg[0] ? mcand_reg : '0);

    assign n_clamp  = (req.item_count > MAX_BINS) ? MAX_BINS : req.item_count;
    assign idx_calc = (dvd_reg[NBIN_W-1:0] >= n_reg) ? BIN_W'(n_reg - 1'b1)
                                                    : dvd_reg[BIN_W-1:0];

    always_comb
    begin
        half_step = step_reg[SAMPLE_W-1:1];
        center    = {1'b0, acc_reg} + (SUM_W+1)'(half_step);
        avg_wide  = (SUM_W+1)'(avg_reg);
        avg_dist  = (avg_wide > center) ? (avg_wide - center) : (center - avg_wide);
        limit     = (MARGIN_W+1)'(half_step) + (MARGIN_W+1)'(margin_reg);
        far       = (avg_dist > (SUM_W+1)'(limit));
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cur_next     = cur_reg;
        bvalid_next  = bvalid_reg;
        n_next       = n_reg;
        avg_next     = avg_reg;
        margin_next  = margin_reg;
        mcand_next   = mcand_reg;
        mplr_next    = mplr_reg;
        acc_next     = acc_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        dvsr_next    = dvsr_reg;
        step_next    = step_reg;
        idx_next     = idx_reg;
        res_bin_next = res_bin_reg;
        changed_next = changed_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    n_next      = n_clamp;
                    avg_next    = req.average;
                    margin_next = req.margin;
                    if (n_clamp == '0)
                    begin
                        // no bins: report zero, keep the stored bin
                        res_bin_next = '0;
                        changed_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        mcand_next = SUM_W'(req.average);
                        mplr_next  = n_clamp;
                        acc_next   = '0;
                        cnt_next   = MUL_A_LAST;
                        state_next = ST_MUL_A;
                    end
                end
            end
            ST_MUL_A:
            begin
                acc_next   = mul_sum;
                mcand_next = {mcand_reg[SUM_W-2:0], 1'b0};
                mplr_next  = {1'b0, mplr_reg[NBIN_W-1:1]};
                if (cnt_reg == '0)
                begin
                    dvd_next   = mul_sum;
                    rem_next   = '0;
                    dvsr_next  = FULL_SCALE;
                    cnt_next   = DIV_LAST;
                    state_next = ST_DIV_A;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DIV_A:
            begin
                rem_next = rem_step;
                dvd_next = dvd_step;
                if (cnt_reg == '0)
                    state_next = ST_DECIDE;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DECIDE:
            begin
                if (!bvalid_reg)
                begin
                    cur_next     = idx_calc;
                    bvalid_next  = 1'b1;
                    res_bin_next = idx_calc;
                    changed_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (idx_calc == cur_reg)
                begin
                    res_bin_next = cur_reg;
                    changed_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    // step width = full scale / bin count
                    idx_next   = idx_calc;
                    dvd_next   = SUM_W'(FULL_SCALE);
                    rem_next   = '0;
                    dvsr_next  = SAMPLE_W'(n_reg);
                    cnt_next   = DIV_LAST;
                    state_next = ST_DIV_S;
                end
            end
            ST_DIV_S:
            begin
                rem_next = rem_step;
                dvd_next = dvd_step;
                if (cnt_reg == '0)
                begin
                    step_next  = dvd_step[SAMPLE_W-1:0];
                    mcand_next = SUM_W'(dvd_step[SAMPLE_W-1:0]);
                    mplr_next  = NBIN_W'(cur_reg);
                    acc_next   = '0;
                    cnt_next   = MUL_C_LAST;
                    state_next = ST_MUL_C;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_MUL_C:
            begin
                acc_next   = mul_sum;
                mcand_next = {mcand_reg[SUM_W-2:0], 1'b0};
                mplr_next  = {1'b0, mplr_reg[NBIN_W-1:1]};
                if (cnt_reg == '0)
                    state_next = ST_CHECK;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_CHECK:
            begin
                if (far)
                begin
                    cur_next     = idx_reg;
                    res_bin_next = idx_reg;
                    changed_next = 1'b1;
                end
                else
                begin
                    res_bin_next = cur_reg;
                    changed_next = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (ack)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            cur_reg    <= '0;
            bvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            cur_reg    <= cur_next;
            bvalid_reg <= bvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        avg_reg     <= avg_next;
        margin_reg  <= margin_next;
        mcand_reg   <= mcand_next;
        mplr_reg    <= mplr_next;
        acc_reg     <= acc_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        dvsr_reg    <= dvsr_next;
        step_reg    <= step_next;
        idx_reg     <= idx_next;
        res_bin_reg <= res_bin_next;
        changed_reg <= changed_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    always_comb
    begin
        result.average     = avg_reg;
        result.bin_index   = res_bin_reg;
        result.bin_changed = changed_reg;
    end

endmodule

### design/averaged_hysteresis_quantizer_unit.sv
// Averages groups of SAMPLE_COUNT (8) potentiometer samples and maps each group average to a
// bin with hysteresis; one word (average, bin_index, bin_changed) leaves per group. Samples
// inside a group are taken one per cycle while in_stall is low. The last sample of a group starts
// the bit-serial bin calculation and the input stalls until its result is taken: a shift-add
// multiply and a restoring division for the bin index, then a decision step, and when the bin
// may move, another division for the step width, a multiply for the bin center and a compare
// step. Results wait in an output register, so later samples of the next group keep flowing
// while a result is stalled, except when a new group completes. Configuration writes are
// always ready and take effect on the next group.
module averaged_hysteresis_quantizer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ahq_pkg::SAMPLE_W-1:0]     sample,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ahq_pkg::SAMPLE_W-1:0]     average,
    output logic [ahq_pkg::BIN_W-1:0]        bin_index,
    output logic                             bin_changed,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ahq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ahq_pkg::MARGIN_W-1:0]     cfg_data
);
    import ahq_pkg::*;

    logic [NBIN_W-1:0]   item_count_reg, item_count_next;
    logic [MARGIN_W-1:0] margin_reg, margin_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic                accept;
    logic [SUM_W-1:0]    sum_add;
    logic [CNT_W-1:0]    count_inc;
    logic                group_end;
    logic [SUM_W-1:0]    avg_full;
    logic [SAMPLE_W-1:0] avg_clamp;
    calc_req_t           req;
    result_t             calc_result;
    logic                calc_busy;
    logic                calc_done;
    logic                load;

    assign accept    = in_valid & ~in_stall;
    assign sum_add   = sum_reg + SUM_W'(sample);
    assign count_inc = count_reg + 1'b1;
    assign group_end = (count_inc == CNT_W'(SAMPLE_COUNT));
    assign avg_full  = sum_add / SUM_W'(SAMPLE_COUNT);
    assign avg_clamp = (avg_full > SUM_W'(FULL_SCALE)) ? FULL_SCALE : avg_full[SAMPLE_W-1:0];

    always_comb
    begin
        req.start      = accept & group_end;
        req.average    = avg_clamp;
        req.item_count = item_count_reg;
        req.margin     = margin_reg;
    end

    ahq_calc u_calc (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .ack    (load),
        .busy   (calc_busy),
        .done   (calc_done),
        .result (calc_result)
    );

    // hold input while a group result is being worked out
    assign in_stall = calc_busy;
    assign load     = calc_done & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        item_count_next = item_count_reg;
        margin_next     = margin_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg & out_stall;
        out_next        = out_reg;

        if (cfg_valid)
        begin
            if (cfg_index == CFG_ITEM_COUNT)
                item_count_next = cfg_data[NBIN_W-1:0];
            else if (cfg_index == CFG_MARGIN)
                margin_next = cfg_data;
        end

        if (accept)
        begin
            if (group_end)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_add;
                count_next = count_inc;
            end
        end

        if (load)
        begin
            out_valid_next = 1'b1;
            out_next       = calc_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= 7'd20;
            margin_reg     <= 10'd15;
            sum_reg        <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_count_reg <= item_count_next;
            margin_reg     <= margin_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign average     = out_reg.average;
    assign bin_index   = out_reg.bin_index;
    assign bin_changed = out_reg.bin_changed;

endmodule
